FILE: src/ppphdlc_pkg.sv
package ppphdlc_pkg;

  localparam logic [2:0] ST_GOOD    = 3'd0;
  localparam logic [2:0] ST_BADFCS  = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_BADADDR = 3'd3;
  localparam logic [2:0] ST_BADCTRL = 3'd4;

  localparam logic [1:0] CFG_SYNC = 2'd0;
  localparam logic [1:0] CFG_ACF  = 2'd1;
  localparam logic [1:0] CFG_PFC  = 2'd2;

  localparam logic [15:0] FCS_INIT    = 16'hFFFF;
  localparam logic [15:0] FCS_POLY    = 16'h8408;
  localparam logic [15:0] FCS_RESIDUE = 16'hF0B8;

  localparam logic [7:0] ADDR_ALL  = 8'hFF;
  localparam logic [7:0] HDLC_CTRL = 8'h03;

  localparam int LEN_W = 12;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      protocol;
    logic [LEN_W-1:0] payload_start;
    logic [LEN_W-1:0] payload_length;
  } out_item_t;

  function automatic logic [15:0] fcs16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: src/ppp_hdlc_frame_receive_checker.sv
// PPP HDLC frame receive checker.
// The input channel (in_valid, in_stall, in_data) takes the unescaped bytes
// of one frame in order, one item per byte, with last_byte set on the final
// byte. A running FCS-16 (held while the sync mode bit is set) and a parse
// of the address, control and protocol fields advance with every byte. The
// final byte of a frame yields one item on the result channel (out_valid,
// out_stall, out_data) with the verdict, the protocol number, the payload
// start and the payload length; other bytes yield no result.
// A final byte is captured in the input register and its result in the
// result register. Throughput is one byte per cycle unless a final byte
// waits on a held result; the per-byte FCS update and header parse sit in
// one stage between the input register and the result register.
// A result held by out_stall does not stop non-final bytes; the next final
// byte waits in the input register and in_stall rises until the result
// register is taken.
// Reset (rst_n low at a clock edge) clears both registers' valid flags, the
// frame state and the three mode registers. The user must write the mode
// registers (cfg_we, cfg_index, cfg_wdata) only between frames; the block does not enforce it.
module ppp_hdlc_frame_receive_checker #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ppphdlc_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ppphdlc_pkg::out_item_t out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic                   cfg_wdata
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int XW = (CW > ppphdlc_pkg::LEN_W) ? CW : ppphdlc_pkg::LEN_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_BYTES);

  localparam logic [1:0] PH_ADDR  = 2'd0;
  localparam logic [1:0] PH_CTRL  = 2'd1;
  localparam logic [1:0] PH_PROTO = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  logic                   sync_r, acf_r, pc_r;
  logic                   s1_valid_r, s1_valid_nxt;
  ppphdlc_pkg::in_item_t  s1_r;
  logic                   out_valid_r, out_valid_nxt;
  ppphdlc_pkg::out_item_t out_data_r, out_data_nxt;

  logic [15:0]   chk_r, chk_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [15:0]   acc_r, acc_nxt;
  logic [2:0]    herr_r, herr_nxt;
  logic [CW-1:0] hb_r, hb_nxt;

  logic          go;
  logic          in_take;
  logic [7:0]    b;
  logic [CW:0]   pos_inc;
  logic [CW:0]   span;
  logic          done;
  logic [CW-1:0] dlen;
  logic [CW-1:0] plen;
  logic [XW-1:0] start_x;
  logic [XW-1:0] plen_x;

  assign go       = s1_valid_r && (!s1_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !go;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    chk_nxt   = chk_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    herr_nxt  = herr_r;
    hb_nxt    = hb_r;
    b         = s1_r.frame_byte;
    pos_inc   = {1'b0, cnt_r} + (CW+1)'(1);
    span      = pos_inc - {1'b0, hb_r};
    done      = 1'b0;
    dlen      = '0;
    plen      = '0;
    start_x   = '0;
    plen_x    = '0;
    out_data_nxt = '0;

    if (!sync_r) begin
      chk_nxt = ppphdlc_pkg::fcs16_byte(chk_r, b);
    end
    if (cnt_r < CNT_MAX) begin
      cnt_nxt = cnt_r + CW'(1);
    end

    case (phase_r)
      PH_ADDR: begin
        first_nxt = b;
        phase_nxt = PH_CTRL;
      end
      PH_CTRL: begin
        if (!acf_r) begin
          if (first_r != ppphdlc_pkg::ADDR_ALL) begin
            herr_nxt = ppphdlc_pkg::ST_BADADDR;
          end else if (b != ppphdlc_pkg::HDLC_CTRL) begin
            herr_nxt = ppphdlc_pkg::ST_BADCTRL;
          end
          hb_nxt    = CW'(2);
          phase_nxt = PH_PROTO;
        end else if (first_r == ppphdlc_pkg::ADDR_ALL && b == ppphdlc_pkg::HDLC_CTRL) begin
          hb_nxt    = CW'(2);
          phase_nxt = PH_PROTO;
        end else begin
          acc_nxt = {acc_r[7:0], first_r};
          if (pc_r && first_r[0]) begin
            hb_nxt    = CW'(1);
            phase_nxt = PH_DONE;
          end else begin
            acc_nxt = {first_r, b};
            if (pc_r && !b[0]) begin
              hb_nxt    = '0;
              phase_nxt = PH_PROTO;
            end else begin
              hb_nxt    = CW'(2);
              phase_nxt = PH_DONE;
            end
          end
        end
      end
      PH_PROTO: begin
        acc_nxt = {acc_r[7:0], b};
        done    = pc_r ? b[0] : (span >= (CW+1)'(2));
        if (done) begin
          hb_nxt    = pos_inc[CW-1:0];
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    dlen    = sync_r ? cnt_nxt : (cnt_nxt - CW'(2));
    plen    = dlen - hb_nxt;
    start_x = XW'(hb_nxt);
    plen_x  = XW'(plen);

    if (cnt_nxt >= CNT_MAX) begin
      out_data_nxt.status = ppphdlc_pkg::ST_BADFCS;
    end else if (!sync_r && chk_nxt != ppphdlc_pkg::FCS_RESIDUE) begin
      out_data_nxt.status = ppphdlc_pkg::ST_BADFCS;
    end else if (sync_r ? (cnt_nxt < CW'(2)) : (cnt_nxt < CW'(4))) begin
      out_data_nxt.status = ppphdlc_pkg::ST_SHORT;
    end else if (herr_nxt != ppphdlc_pkg::ST_GOOD) begin
      out_data_nxt.status = herr_nxt;
    end else if (phase_nxt != PH_DONE || hb_nxt > dlen) begin
      out_data_nxt.status = ppphdlc_pkg::ST_SHORT;
    end else begin
      out_data_nxt.status         = ppphdlc_pkg::ST_GOOD;
      out_data_nxt.protocol       = acc_nxt;
      out_data_nxt.payload_start  = start_x[ppphdlc_pkg::LEN_W-1:0];
      out_data_nxt.payload_length = plen_x[ppphdlc_pkg::LEN_W-1:0];
    end

    if (s1_r.last_byte) begin
      chk_nxt   = ppphdlc_pkg::FCS_INIT;
      cnt_nxt   = '0;
      first_nxt = '0;
      phase_nxt = PH_ADDR;
      acc_nxt   = '0;
      herr_nxt  = ppphdlc_pkg::ST_GOOD;
      hb_nxt    = '0;
    end
  end

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (go && s1_r.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= 1'b0;
      acf_r       <= 1'b0;
      pc_r        <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      chk_r       <= ppphdlc_pkg::FCS_INIT;
      cnt_r       <= '0;
      first_r     <= '0;
      phase_r     <= PH_ADDR;
      acc_r       <= '0;
      herr_r      <= ppphdlc_pkg::ST_GOOD;
      hb_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ppphdlc_pkg::CFG_SYNC: sync_r <= cfg_wdata;
          ppphdlc_pkg::CFG_ACF:  acf_r  <= cfg_wdata;
          ppphdlc_pkg::CFG_PFC:  pc_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (go) begin
        chk_r   <= chk_nxt;
        cnt_r   <= cnt_nxt;
        first_r <= first_nxt;
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        herr_r  <= herr_nxt;
        hb_r    <= hb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_data;
    end
    if (go && s1_r.last_byte) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_r.last_byte && out_valid_r)
    else $error("input stalled without a waiting final byte");

  a_bad_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ppphdlc_pkg::ST_GOOD |->
      out_data_r.protocol == '0 && out_data_r.payload_start == '0 &&
      out_data_r.payload_length == '0)
    else $error("fields set on a rejected frame");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.status <= ppphdlc_pkg::ST_BADCTRL)
    else $error("status code out of range");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    go && s1_r.last_byte |=> cnt_r == '0 && phase_r == PH_ADDR && out_valid_r)
    else $error("frame state not cleared after final byte");

  a_done_has_header: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> hb_r != '0)
    else $error("protocol complete with empty header count");

endmodule
